/* design/lfht_pkg.sv */
// ----------------------------------------------------------------------------
// lfht_pkg
// Shared codes and types for the lowest-free handle table.
// ----------------------------------------------------------------------------
`default_nettype none

package lfht_pkg;

  localparam int SLOT_IDX_BITS = 6;

  localparam logic [2:0] MODE_ALLOC_LOW = 3'd0;
  localparam logic [2:0] MODE_ALLOC_AT  = 3'd1;
  localparam logic [2:0] MODE_FREE      = 3'd2;
  localparam logic [2:0] MODE_QUERY     = 3'd3;
  localparam logic [2:0] MODE_SET_FLAGS = 3'd4;
  localparam logic [2:0] MODE_SWEEP     = 3'd5;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_FULL     = 3'd1;
  localparam logic [2:0] ST_IN_USE   = 3'd2;
  localparam logic [2:0] ST_BAD_SLOT = 3'd3;
  localparam logic [2:0] ST_EMPTY    = 3'd4;
  localparam logic [2:0] ST_ZERO     = 3'd5;
  localparam logic [2:0] ST_NONE     = 3'd6;

  // update request for the valid-bit array
  typedef struct packed {
    logic                     set;
    logic                     clr;
    logic [SLOT_IDX_BITS-1:0] idx;
  } valid_op_t;

endpackage

`default_nettype wire

/* design/lfht_ram.sv */
// ----------------------------------------------------------------------------
// lfht_ram
// Simple dual-port RAM, one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module lfht_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* design/lfht_valid.sv */
// ----------------------------------------------------------------------------
// lfht_valid
// Per-slot occupancy bits with a lowest-free priority encoder.
// ----------------------------------------------------------------------------
`default_nettype none

module lfht_valid
  import lfht_pkg::*;
#(
  parameter int SLOT_COUNT = 64,
  localparam int SW = $clog2(SLOT_COUNT)
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire valid_op_t             op,
  output logic [SLOT_COUNT-1:0]      valid,
  output logic                       free_found,
  output logic [SW-1:0]              free_idx
);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (op.set) begin
        valid[op.idx[SW-1:0]] <= 1'b1;
      end
      if (op.clr) begin
        valid[op.idx[SW-1:0]] <= 1'b0;
      end
    end
  end

  // scan downwards so the lowest clear bit wins
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (!valid[i]) begin
        free_found = 1'b1;
        free_idx   = SW'(i);
      end
    end
  end

endmodule

`default_nettype wire

/* design/lowest_free_handle_table.sv */
// ----------------------------------------------------------------------------
// lowest_free_handle_table
// Slot table of handles and flags with lowest-free allocation and sweep.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: an item is taken on a clock edge with start high and
//   busy low. Results come out on status/slot_out/handle_out/flags_out/last,
//   each beat shown for one cycle while done is high; there is no back
//   pressure, the receiver must take every beat.
//   Config channel: cfg_data is written to the close-on-exec mask when
//   cfg_valid and cfg_ready are both high; cfg_ready is low while busy.
//   Timing: handles and flags live in two RAMs with a registered read,
//   occupancy bits in flops. A single-slot command reads the RAMs in the
//   accept cycle and resolves in the next; its beat is registered from
//   that resolving cycle, and busy stays high until it has resolved.
//   A sweep reads one slot per cycle: busy stays high through the scan
//   and a flush state, the final beat (last high, or a nothing-closed beat)
//   is registered from the flush state, and the next command can be taken
//   once busy has fallen. Freed beats trail the scan by one found slot so
//   last can be marked.
//   Reset: occupancy bits clear at once (table empty), mask becomes 1; the
//   RAM contents are only read for occupied slots and need no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module lowest_free_handle_table
  import lfht_pkg::*;
#(
  parameter int SLOT_COUNT  = 64,
  parameter int HANDLE_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  mode,
  input  wire logic [7:0]  slot,
  input  wire logic [31:0] handle,
  input  wire logic [31:0] flag_word,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [31:0] cfg_data,
  output logic             done,
  output logic [2:0]       status,
  output logic [5:0]       slot_out,
  output logic [31:0]      handle_out,
  output logic [31:0]      flags_out,
  output logic             last
);

  localparam int SW = $clog2(SLOT_COUNT);
  localparam int HW = (HANDLE_BITS < 32) ? HANDLE_BITS : 32;
  localparam logic [SW-1:0] LAST_SLOT = SW'(SLOT_COUNT - 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_EXEC  = 2'd1;
  localparam logic [1:0] S_SWEEP = 2'd2;
  localparam logic [1:0] S_FLUSH = 2'd3;

  logic [1:0]  state, state_next;
  logic [SW-1:0] scan, scan_next;
  logic [2:0]  mode_r;
  logic [7:0]  slot_r;
  logic [HW-1:0] handle_r;
  logic [31:0] flags_r;
  logic [31:0] mask;

  logic          pend, pend_next;
  logic [SW-1:0] pend_slot, pend_slot_next;
  logic [HW-1:0] pend_handle, pend_handle_next;

  logic          emit;
  logic [2:0]    st_n;
  logic [SW-1:0] so_n;
  logic [HW-1:0] ho_n;
  logic [31:0]   fo_n;
  logic          last_n;

  logic          h_we, f_we;
  logic [SW-1:0] w_addr, r_addr;
  logic [HW-1:0] rd_handle;
  logic [31:0]   rd_flags;

  valid_op_t             vop;
  logic [SLOT_COUNT-1:0] valid_vec;
  logic                  free_found;
  logic [SW-1:0]         free_idx;

  logic in_range, hzero, occ, hit;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = !busy;

  lfht_ram #(.WIDTH(HW), .DEPTH(SLOT_COUNT)) u_handle_ram (
    .clk  (clk),
    .we   (h_we),
    .waddr(w_addr),
    .wdata(handle_r),
    .raddr(r_addr),
    .rdata(rd_handle)
  );

  lfht_ram #(.WIDTH(32), .DEPTH(SLOT_COUNT)) u_flags_ram (
    .clk  (clk),
    .we   (f_we),
    .waddr(w_addr),
    .wdata(flags_r),
    .raddr(r_addr),
    .rdata(rd_flags)
  );

  lfht_valid #(.SLOT_COUNT(SLOT_COUNT)) u_valid (
    .clk       (clk),
    .rst       (rst),
    .op        (vop),
    .valid     (valid_vec),
    .free_found(free_found),
    .free_idx  (free_idx)
  );

  assign in_range = (slot_r < 8'(SLOT_COUNT));
  assign hzero    = (handle_r == '0);
  assign occ      = valid_vec[slot_r[SW-1:0]];
  assign hit      = valid_vec[scan] && ((rd_flags & mask) != '0);

  always_comb begin
    state_next       = state;
    scan_next        = scan;
    pend_next        = pend;
    pend_slot_next   = pend_slot;
    pend_handle_next = pend_handle;
    emit   = 1'b0;
    st_n   = ST_OK;
    so_n   = '0;
    ho_n   = '0;
    fo_n   = '0;
    last_n = 1'b1;
    h_we   = 1'b0;
    f_we   = 1'b0;
    w_addr = slot_r[SW-1:0];
    r_addr = slot[SW-1:0];
    vop    = '0;

    unique case (state)
      S_IDLE: begin
        r_addr = (mode == MODE_SWEEP) ? '0 : slot[SW-1:0];
        if (start) begin
          if (mode == MODE_SWEEP) begin
            state_next = S_SWEEP;
            scan_next  = '0;
            pend_next  = 1'b0;
          end else begin
            state_next = S_EXEC;
          end
        end
      end

      S_EXEC: begin
        state_next = S_IDLE;
        unique case (mode_r)
          MODE_ALLOC_LOW: begin
            emit = 1'b1;
            if (hzero) begin
              st_n = ST_ZERO;
            end else if (!free_found) begin
              st_n = ST_FULL;
            end else begin
              so_n    = free_idx;
              w_addr  = free_idx;
              h_we    = 1'b1;
              f_we    = 1'b1;
              vop.set = 1'b1;
              vop.idx = SLOT_IDX_BITS'(free_idx);
            end
          end
          MODE_ALLOC_AT: begin
            emit = 1'b1;
            if (!in_range) begin
              st_n = ST_BAD_SLOT;
            end else begin
              so_n = slot_r[SW-1:0];
              if (hzero) begin
                st_n = ST_ZERO;
              end else if (occ) begin
                st_n = ST_IN_USE;
              end else begin
                h_we    = 1'b1;
                f_we    = 1'b1;
                vop.set = 1'b1;
                vop.idx = SLOT_IDX_BITS'(slot_r[SW-1:0]);
              end
            end
          end
          MODE_FREE, MODE_QUERY, MODE_SET_FLAGS: begin
            emit = 1'b1;
            if (!in_range) begin
              st_n = ST_BAD_SLOT;
            end else begin
              so_n = slot_r[SW-1:0];
              if (!occ) begin
                st_n = ST_EMPTY;
              end else if (mode_r == MODE_FREE) begin
                ho_n    = rd_handle;
                vop.clr = 1'b1;
                vop.idx = SLOT_IDX_BITS'(slot_r[SW-1:0]);
              end else if (mode_r == MODE_QUERY) begin
                ho_n = rd_handle;
                fo_n = rd_flags;
              end else begin
                f_we = 1'b1;
              end
            end
          end
          default: begin
            // unused modes: no beat, no table update; back to idle
          end
        endcase
      end

      S_SWEEP: begin
        r_addr = (scan == LAST_SLOT) ? '0 : scan + 1'b1;
        if (hit) begin
          vop.clr = 1'b1;
          vop.idx = SLOT_IDX_BITS'(scan);
          if (pend) begin
            emit   = 1'b1;
            so_n   = pend_slot;
            ho_n   = pend_handle;
            last_n = 1'b0;
          end
          pend_next        = 1'b1;
          pend_slot_next   = scan;
          pend_handle_next = rd_handle;
        end
        if (scan == LAST_SLOT) begin
          state_next = S_FLUSH;
        end else begin
          scan_next = scan + 1'b1;
        end
      end

      S_FLUSH: begin
        state_next = S_IDLE;
        emit       = 1'b1;
        if (pend) begin
          so_n = pend_slot;
          ho_n = pend_handle;
        end else begin
          st_n = ST_NONE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      scan  <= '0;
      pend  <= 1'b0;
      done  <= 1'b0;
      mask  <= 32'd1;
    end else begin
      state <= state_next;
      scan  <= scan_next;
      pend  <= pend_next;
      done  <= emit;
      if (cfg_valid && cfg_ready) begin
        mask <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      mode_r   <= mode;
      slot_r   <= slot;
      handle_r <= handle[HW-1:0];
      flags_r  <= flag_word;
    end
    pend_slot   <= pend_slot_next;
    pend_handle <= pend_handle_next;
    if (emit) begin
      status     <= st_n;
      slot_out   <= 6'(so_n);
      handle_out <= 32'(ho_n);
      flags_out  <= fo_n;
      last       <= last_n;
    end
  end

  // a final beat is never followed straight away by another
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    done && last |=> !done)
    else $error("beat directly after a last beat");

  a_sweep_start: assert property (@(posedge clk) disable iff (rst)
    start && !busy && mode == MODE_SWEEP |=> state == S_SWEEP && scan == '0)
    else $error("sweep did not start at slot zero");

  a_alloc_marks: assert property (@(posedge clk) disable iff (rst)
    done && status == ST_OK && mode_r == MODE_ALLOC_LOW
      |-> valid_vec[slot_out[SW-1:0]])
    else $error("allocated slot not marked occupied");

  a_none_last: assert property (@(posedge clk) disable iff (rst)
    done && status == ST_NONE |-> last && slot_out == '0)
    else $error("nothing-closed beat malformed");

  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !vop.set && !vop.clr && !h_we && !f_we)
    else $error("table update while idle");

endmodule

`default_nettype wire

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the lowest-free handle table. A shadow copy of the
// slots and the close-on-exec mask predicts every result beat of each
// accepted command, and every beat on the done strobe is checked against it
// field by field. A short directed opening is followed by random traffic.
// This traffic includes a full-table fill and wide sweeps, and runs under
// several mask settings and sender idling patterns.
// ----------------------------------------------------------------------------

package lfht_tb_pkg;
  import lfht_pkg::*;

  localparam int SLOTS = 64;

  // modes the block takes but ignores
  localparam logic [2:0] MODE_SPARE_LO = 3'd6;
  localparam logic [2:0] MODE_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [2:0]  status;
    logic [5:0]  slot_out;
    logic [31:0] handle_out;
    logic [31:0] flags_out;
    logic        last;
  } table_beat_t;

  class handle_table_shadow;
    bit          occupied [SLOTS];
    logic [31:0] held_handle [SLOTS];
    logic [31:0] held_flags [SLOTS];
    logic [31:0] coe_mask;
    table_beat_t awaited_beats [$];
    int          errors;

    function new();
      foreach (occupied[k]) occupied[k] = 1'b0;
      coe_mask = 32'd1;
      errors   = 0;
    endfunction

    function void set_mask(logic [31:0] value);
      coe_mask = value;
    endfunction

    function int live_count();
      int n;
      n = 0;
      foreach (occupied[k]) if (occupied[k]) n++;
      return n;
    endfunction

    function int any_occupied_slot();
      int live [$];
      foreach (occupied[k]) if (occupied[k]) live.push_back(k);
      if (live.size() == 0) return -1;
      return live[$urandom_range(live.size() - 1)];
    endfunction

    function void expect_beat(logic [2:0] st, int s, logic [31:0] h, logic [31:0] f, bit l);
      table_beat_t b;
      b.status     = st;
      b.slot_out   = 6'(s);
      b.handle_out = h;
      b.flags_out  = f;
      b.last       = l;
      awaited_beats.push_back(b);
    endfunction

    // Work out the beats one accepted command causes and update the slots.
    function void take_command(logic [2:0] op, logic [7:0] s, logic [31:0] h,
                               logic [31:0] f);
      int idx;
      int swept;
      int n;
      idx = int'(s[5:0]);
      if (op == MODE_ALLOC_LOW) begin
        if (h == 32'd0) begin
          expect_beat(ST_ZERO, 0, 32'd0, 32'd0, 1'b1);
          return;
        end
        for (int k = 0; k < SLOTS; k++) begin
          if (!occupied[k]) begin
            occupied[k]    = 1'b1;
            held_handle[k] = h;
            held_flags[k]  = f;
            expect_beat(ST_OK, k, 32'd0, 32'd0, 1'b1);
            return;
          end
        end
        expect_beat(ST_FULL, 0, 32'd0, 32'd0, 1'b1);
      end else if (op == MODE_SWEEP) begin
        swept = 0;
        foreach (occupied[k]) if (occupied[k] && (held_flags[k] & coe_mask) != 32'd0) swept++;
        if (swept == 0) begin
          expect_beat(ST_NONE, 0, 32'd0, 32'd0, 1'b1);
          return;
        end
        n = 0;
        for (int k = 0; k < SLOTS; k++) begin
          if (occupied[k] && (held_flags[k] & coe_mask) != 32'd0) begin
            n++;
            expect_beat(ST_OK, k, held_handle[k], 32'd0, n == swept);
            occupied[k]   = 1'b0;
            held_flags[k] = 32'd0;
          end
        end
      end else if (op == MODE_ALLOC_AT || op == MODE_FREE || op == MODE_QUERY ||
                   op == MODE_SET_FLAGS) begin
        if (int'(s) >= SLOTS) begin
          expect_beat(ST_BAD_SLOT, 0, 32'd0, 32'd0, 1'b1);
        end else if (op == MODE_ALLOC_AT) begin
          if (h == 32'd0) begin
            expect_beat(ST_ZERO, idx, 32'd0, 32'd0, 1'b1);
          end else if (occupied[idx]) begin
            expect_beat(ST_IN_USE, idx, 32'd0, 32'd0, 1'b1);
          end else begin
            occupied[idx]    = 1'b1;
            held_handle[idx] = h;
            held_flags[idx]  = f;
            expect_beat(ST_OK, idx, 32'd0, 32'd0, 1'b1);
          end
        end else if (!occupied[idx]) begin
          expect_beat(ST_EMPTY, idx, 32'd0, 32'd0, 1'b1);
        end else if (op == MODE_FREE) begin
          expect_beat(ST_OK, idx, held_handle[idx], 32'd0, 1'b1);
          occupied[idx]   = 1'b0;
          held_flags[idx] = 32'd0;
        end else if (op == MODE_QUERY) begin
          expect_beat(ST_OK, idx, held_handle[idx], held_flags[idx], 1'b1);
        end else begin
          held_flags[idx] = f;
          expect_beat(ST_OK, idx, 32'd0, 32'd0, 1'b1);
        end
      end
      // spare modes cause nothing
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $display("%0t  %s mismatch: expected %0h, got %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_beat(logic [2:0] st, logic [5:0] so, logic [31:0] ho,
                             logic [31:0] fo, logic lst);
      table_beat_t want;
      if (awaited_beats.size() == 0) begin
        $display("%0t  unexpected beat: expected none, got status %0d slot %0d handle %0h",
                 $time, st, so, ho);
        errors++;
        return;
      end
      want = awaited_beats.pop_front();
      compare_field("status", 32'(want.status), 32'(st));
      compare_field("slot_out", 32'(want.slot_out), 32'(so));
      compare_field("handle_out", want.handle_out, ho);
      compare_field("flags_out", want.flags_out, fo);
      compare_field("last", 32'(want.last), 32'(lst));
    endfunction
  endclass

endpackage

module tb_top;
  import lfht_pkg::*;
  import lfht_tb_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [2:0]  mode;
  logic [7:0]  slot;
  logic [31:0] handle;
  logic [31:0] flag_word;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [31:0] cfg_data;
  logic        done;
  logic [2:0]  status;
  logic [5:0]  slot_out;
  logic [31:0] handle_out;
  logic [31:0] flags_out;
  logic        last;

  handle_table_shadow shadow;
  int stalled_cycles = 0;

  lowest_free_handle_table DUT (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .mode       (mode),
    .slot       (slot),
    .handle     (handle),
    .flag_word  (flag_word),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .done       (done),
    .status     (status),
    .slot_out   (slot_out),
    .handle_out (handle_out),
    .flags_out  (flags_out),
    .last       (last)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    if (!rst && done) shadow.check_beat(status, slot_out, handle_out, flags_out, last);
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
      stalled_cycles <= 0;
    end else if (stalled_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      stalled_cycles <= stalled_cycles + 1;
    end
  end

  // Entered and left at a falling edge; start is left high on return.
  task automatic send_command(input logic [2:0] op, input logic [7:0] s,
                              input logic [31:0] h, input logic [31:0] f,
                              input int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start     <= 1'b1;
    mode      <= op;
    slot      <= s;
    handle    <= h;
    flag_word <= f;
    @(posedge clk);
    while (busy) @(posedge clk);
    shadow.take_command(op, s, h, f);
    @(negedge clk);
  endtask

  task automatic wait_for_results();
    start <= 1'b0;
    @(negedge clk);
    while (shadow.awaited_beats.size() != 0) @(negedge clk);
  endtask

  task automatic write_mask(input logic [31:0] value);
    wait_for_results();
    // an ignored command gives no beat but may still be in flight
    repeat (SLOTS + 16) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    shadow.set_mask(value);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [31:0] random_flags();
    case ($urandom_range(3))
      0: return 32'd0;
      1: return 32'd1 << $urandom_range(31);
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [31:0] random_handle();
    logic [31:0] v;
    v = $urandom();
    case ($urandom_range(15))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      default: return (v == 32'd0) ? 32'd1 : v;
    endcase
  endfunction

  task automatic random_item(input int idle_pct, input int pause_pct, output bit counted);
    int          pick;
    int          live;
    logic [2:0]  op;
    logic [7:0]  s;
    if ($urandom_range(99) < pause_pct) wait_for_results();
    pick = $urandom_range(99);
    if (pick < 25) op = MODE_ALLOC_LOW;
    else if (pick < 40) op = MODE_ALLOC_AT;
    else if (pick < 55) op = MODE_FREE;
    else if (pick < 70) op = MODE_QUERY;
    else if (pick < 86) op = MODE_SET_FLAGS;
    else if (pick < 93) op = MODE_SWEEP;
    else op = ($urandom_range(1) == 1) ? MODE_SPARE_HI : MODE_SPARE_LO;
    // bias free, query and set-flags commands towards live slots so they reach the ok paths
    live = shadow.any_occupied_slot();
    pick = $urandom_range(9);
    if (pick == 0) s = 8'($urandom_range(255, SLOTS));
    else if (pick <= 5 && live >= 0 &&
             (op == MODE_FREE || op == MODE_QUERY || op == MODE_SET_FLAGS)) s = 8'(live);
    else s = 8'($urandom_range(SLOTS - 1));
    send_command(op, s, random_handle(), random_flags(), idle_pct);
    counted = (op != MODE_SPARE_LO && op != MODE_SPARE_HI);
  endtask

  task automatic run_random(input int items, input int idle_pct, input int pause_pct);
    int taken;
    bit counted;
    taken = 0;
    while (taken < items) begin
      random_item(idle_pct, pause_pct, counted);
      if (counted) taken++;
    end
  endtask

  // Fill every free slot, then hit the full and in-use cases.
  task automatic fill_table(input int idle_pct);
    logic [31:0] h;
    logic [31:0] f;
    while (shadow.live_count() < SLOTS) begin
      h = $urandom();
      if (h == 32'd0) h = 32'd1;
      f = random_flags();
      if (f == 32'd0) f = 32'h8000_0000;
      send_command(MODE_ALLOC_LOW, 8'($urandom), h, f, idle_pct);
    end
    send_command(MODE_ALLOC_LOW, 8'($urandom), 32'hFFFF_FFFF, $urandom(), idle_pct);
    send_command(MODE_ALLOC_AT, 8'($urandom_range(SLOTS - 1)), 32'd3, $urandom(), idle_pct);
  endtask

  initial begin
    shadow    = new();
    rst       = 1'b1;
    start     = 1'b0;
    mode      = MODE_ALLOC_LOW;
    slot      = 8'd0;
    handle    = 32'd0;
    flag_word = 32'd0;
    cfg_valid = 1'b0;
    cfg_data  = 32'd0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed opening, mask at its reset value
    send_command(MODE_QUERY,     8'd0,   32'd0,         32'd0,         0);
    send_command(MODE_ALLOC_LOW, 8'd0,   32'd0,         32'd0,         0);
    send_command(MODE_ALLOC_LOW, 8'd0,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
    send_command(MODE_ALLOC_AT,  8'd63,  32'd1,         32'd0,         0);
    send_command(MODE_ALLOC_AT,  8'd255, 32'd0,         32'd0,         0);
    send_command(MODE_ALLOC_AT,  8'd64,  32'd5,         32'd1,         0);
    send_command(MODE_ALLOC_AT,  8'd5,   32'd0,         32'd1,         0);
    send_command(MODE_ALLOC_AT,  8'd63,  32'd7,         32'd1,         0);
    send_command(MODE_QUERY,     8'd0,   32'd0,         32'd0,         0);
    send_command(MODE_QUERY,     8'd63,  32'd0,         32'd0,         0);
    send_command(MODE_SET_FLAGS, 8'd63,  32'd0,         32'h8000_0000, 0);
    send_command(MODE_SET_FLAGS, 8'd10,  32'd0,         32'd1,         0);
    send_command(MODE_FREE,      8'd200, 32'd0,         32'd0,         0);
    send_command(MODE_QUERY,     8'd128, 32'd0,         32'd0,         0);
    send_command(MODE_SET_FLAGS, 8'd64,  32'd0,         32'd1,         0);
    send_command(MODE_SPARE_LO,  8'd1,   32'd9,         32'd1,         0);
    send_command(MODE_SPARE_HI,  8'd2,   32'd9,         32'd1,         0);
    send_command(MODE_FREE,      8'd0,   32'd0,         32'd0,         0);
    send_command(MODE_FREE,      8'd0,   32'd0,         32'd0,         0);
    send_command(MODE_SWEEP,     8'd0,   32'd0,         32'd0,         0);
    send_command(MODE_ALLOC_LOW, 8'd0,   32'h1234_5678, 32'd3,         0);
    send_command(MODE_ALLOC_LOW, 8'd0,   32'd9,         32'd1,         0);
    send_command(MODE_SWEEP,     8'd0,   32'd0,         32'd0,         0);
    send_command(MODE_QUERY,     8'd63,  32'd0,         32'd0,         0);

    write_mask(32'hFFFF_FFFF);
    run_random(12, 0, 0);

    // mask cleared: sweeps release nothing, so the table fills up
    write_mask(32'd0);
    fill_table(75);
    run_random(10, 75, 0);

    // all bits set: the opening sweep empties nearly the whole table
    write_mask(32'hFFFF_FFFF);
    send_command(MODE_SWEEP, 8'($urandom), $urandom(), $urandom(), 0);
    run_random(10, 0, 0);

    write_mask($urandom());
    run_random(12, 13, 10);

    wait_for_results();
    repeat (SLOTS + 20) @(negedge clk);
    if (shadow.errors == 0 && shadow.awaited_beats.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
